[rtl/falc_pkg.sv]
// Shared types, sizes and action codes for the fully associative LRU cache.
package falc_pkg;

    localparam int ENTRIES     = 8;
    localparam int BLOCK_BYTES = 4;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OFFSET_W    = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;
    localparam int ADDR_W      = 16;
    localparam int TAG_W       = 14;
    localparam int DATA_W      = 32;
    localparam int STAMP_W     = 32;
    localparam int CNT_W       = 32;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ACT_LOOKUP     = 2'd0,
        ACT_INSERT     = 2'd1,
        ACT_INVALIDATE = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    // Write request into the entry store
    typedef struct packed {
        logic               fill_en;   // write valid, tag, block and stamp
        logic               stamp_en;  // restamp only
        logic               inv_all;   // clear every valid bit
        logic [IDX_W-1:0]   idx;
        logic [TAG_W-1:0]   tag;
        logic [DATA_W-1:0]  block;
        logic [STAMP_W-1:0] stamp;
    } store_wr_t;

    // Contents of the entry under the scan pointer
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [DATA_W-1:0]  block;
        logic [STAMP_W-1:0] stamp;
    } entry_rd_t;

    // Result of the shared compare unit
    typedef struct packed {
        logic tag_eq;
        logic stamp_lt;
    } cmp_res_t;

    // Extract the block tag from a byte address
    function automatic logic [TAG_W-1:0] block_tag(input logic [ADDR_W-1:0] address);
        block_tag = TAG_W'(address >> OFFSET_W);
    endfunction

endpackage

[rtl/falc_entry_store.sv]
// Entry store: valid bits, tags, blocks and LRU stamps with one scan read port.
module falc_entry_store
    import falc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_wr_t        wr,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_rd_t        rd
);

    logic [ENTRIES-1:0] valid_reg;
    logic [STAMP_W-1:0] stamp_reg [ENTRIES];
    logic [TAG_W-1:0]   tag_reg   [ENTRIES];
    logic [DATA_W-1:0]  block_reg [ENTRIES];

    // Update valid bits and stamps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.inv_all)
            begin
                valid_reg <= '0;
            end
            else if (wr.fill_en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (wr.fill_en || wr.stamp_en)
            begin
                stamp_reg[wr.idx] <= wr.stamp;
            end
        end
    end

    // Write tag and block payload on a fill
    always_ff @(posedge clk)
    begin
        if (wr.fill_en)
        begin
            tag_reg[wr.idx]   <= wr.tag;
            block_reg[wr.idx] <= wr.block;
        end
    end

    // Read the entry under the scan pointer
    assign rd.valid = valid_reg[rd_idx];
    assign rd.tag   = tag_reg[rd_idx];
    assign rd.block = block_reg[rd_idx];
    assign rd.stamp = stamp_reg[rd_idx];

endmodule

[rtl/falc_cmp_unit.sv]
// Shared compare unit: tag match and stamp ordering for one entry per cycle.
module falc_cmp_unit
    import falc_pkg::*;
(
    input  logic [TAG_W-1:0]   req_tag,
    input  logic [TAG_W-1:0]   entry_tag,
    input  logic [STAMP_W-1:0] entry_stamp,
    input  logic [STAMP_W-1:0] best_stamp,
    output cmp_res_t           res
);

    // Compare the scanned entry against the request tag and the best stamp
    assign res.tag_eq   = (req_tag == entry_tag);
    assign res.stamp_lt = (entry_stamp < best_stamp);

endmodule

[rtl/fully_assoc_lru_data_cache_unit.sv]
// Top level: request sequencer, statistics and output register of the LRU cache.
//
// Usage:
//   Requests arrive on the s_* stream: s_tuser carries the action (lookup,
//   insert, invalidate all, clear statistics), s_tdata the address and the
//   fill block. One result per request leaves on the m_* stream: m_tuser
//   carries the hit flag, m_tdata the read block and both saturating totals.
//   A lookup or insert walks the entries one per cycle through a single
//   compare unit; a lookup stops at the first match, an insert at the first
//   free entry, otherwise it visits all entries to find the oldest stamp.
//   Invalidate and clear go from capture straight to the commit step, lookup
//   and insert pass through the scan first. s_tready is high only while no
//   request is in work, so no new request is taken before the last one
//   has committed.
//   A finished result waits in the output register while the next request
//   is taken; if the receiver stalls, the sequencer holds at its final step
//   until the register frees up. Reset clears all valid bits, stamps, the
//   stamp counter and both totals; tags and blocks are written before use.
module fully_assoc_lru_data_cache_unit
    import falc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] address, [47:16] fill_block
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] read_block, [63:32] hit_total, [95:64] miss_total
    output logic [0:0]  m_tuser    // [0] hit
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg,     state_next;
    action_t            action_reg,    action_next;
    logic [TAG_W-1:0]   tag_reg,       tag_next;
    logic [DATA_W-1:0]  fill_reg,      fill_next;
    logic [IDX_W-1:0]   scan_idx_reg,  scan_idx_next;
    logic [IDX_W-1:0]   sel_idx_reg,   sel_idx_next;
    logic               found_reg,     found_next;
    logic [DATA_W-1:0]  sel_block_reg, sel_block_next;
    logic [STAMP_W-1:0] best_reg,      best_next;
    logic [STAMP_W-1:0] stamp_cnt_reg, stamp_cnt_next;
    logic [CNT_W-1:0]   hit_cnt_reg,   hit_cnt_next;
    logic [CNT_W-1:0]   miss_cnt_reg,  miss_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg,   out_hit_next;
    logic [DATA_W-1:0]  out_block_reg, out_block_next;
    logic [CNT_W-1:0]   out_hits_reg,  out_hits_next;
    logic [CNT_W-1:0]   out_miss_reg,  out_miss_next;

    store_wr_t wr;
    entry_rd_t rd;
    cmp_res_t  cmp;
    logic      in_xfer;
    logic      finish;
    logic      last_idx;

    falc_entry_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_idx (scan_idx_reg),
        .rd     (rd)
    );

    falc_cmp_unit u_cmp (
        .req_tag     (tag_reg),
        .entry_tag   (rd.tag),
        .entry_stamp (rd.stamp),
        .best_stamp  (best_reg),
        .res         (cmp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign last_idx = (scan_idx_reg == LAST_IDX);

    // Sequence one request: capture, scan, commit
    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        tag_next       = tag_reg;
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        sel_idx_next   = sel_idx_reg;
        found_next     = found_reg;
        sel_block_next = sel_block_reg;
        best_next      = best_reg;
        stamp_cnt_next = stamp_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_hit_next   = out_hit_reg;
        out_block_next = out_block_reg;
        out_hits_next  = out_hits_reg;
        out_miss_next  = out_miss_reg;

        wr          = '0;
        wr.idx      = sel_idx_reg;
        wr.tag      = tag_reg;
        wr.block    = fill_reg;
        wr.stamp    = stamp_cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    action_next   = action_t'(s_tuser);
                    tag_next      = block_tag(s_tdata[15:0]);
                    fill_next     = s_tdata[47:16];
                    scan_idx_next = '0;
                    sel_idx_next  = '0;
                    found_next    = 1'b0;
                    if (action_t'(s_tuser) == ACT_LOOKUP || action_t'(s_tuser) == ACT_INSERT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (action_reg == ACT_LOOKUP)
                begin
                    // Stop at the lowest matching valid entry
                    if (rd.valid && cmp.tag_eq)
                    begin
                        found_next     = 1'b1;
                        sel_idx_next   = scan_idx_reg;
                        sel_block_next = rd.block;
                        state_next     = ST_DONE;
                    end
                    else if (last_idx)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    // Take the first free entry, else track the oldest stamp
                    if (!rd.valid)
                    begin
                        sel_idx_next = scan_idx_reg;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        if (scan_idx_reg == '0 || cmp.stamp_lt)
                        begin
                            sel_idx_next = scan_idx_reg;
                            best_next    = rd.stamp;
                        end
                        if (last_idx)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            scan_idx_next = scan_idx_reg + 1'b1;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (finish)
                begin
                    unique case (action_reg)
                        ACT_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                wr.stamp_en    = 1'b1;
                                stamp_cnt_next = stamp_cnt_reg + 1'b1;
                                if (hit_cnt_reg != '1)
                                begin
                                    hit_cnt_next = hit_cnt_reg + 1'b1;
                                end
                            end
                            else if (miss_cnt_reg != '1)
                            begin
                                miss_cnt_next = miss_cnt_reg + 1'b1;
                            end
                        end
                        ACT_INSERT:
                        begin
                            wr.fill_en     = 1'b1;
                            stamp_cnt_next = stamp_cnt_reg + 1'b1;
                        end
                        ACT_INVALIDATE:
                        begin
                            wr.inv_all = 1'b1;
                        end
                        ACT_CLEAR:
                        begin
                            hit_cnt_next  = '0;
                            miss_cnt_next = '0;
                        end
                        default:
                        begin
                            hit_cnt_next = hit_cnt_reg;
                        end
                    endcase

                    // Load the result register
                    out_valid_next = 1'b1;
                    out_hit_next   = (action_reg == ACT_LOOKUP) && found_reg;
                    out_block_next = ((action_reg == ACT_LOOKUP) && found_reg) ?
                                     sel_block_reg : '0;
                    out_hits_next  = hit_cnt_next;
                    out_miss_next  = miss_cnt_next;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stamp_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stamp_cnt_reg <= stamp_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold request and result payload
    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        tag_reg       <= tag_next;
        fill_reg      <= fill_next;
        scan_idx_reg  <= scan_idx_next;
        sel_idx_reg   <= sel_idx_next;
        found_reg     <= found_next;
        sel_block_reg <= sel_block_next;
        best_reg      <= best_next;
        out_hit_reg   <= out_hit_next;
        out_block_reg <= out_block_next;
        out_hits_reg  <= out_hits_next;
        out_miss_reg  <= out_miss_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_hit_reg;
    assign m_tdata    = {out_miss_reg, out_hits_reg, out_block_reg};

`ifndef SYNTH
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("request taken while a request is in work");

    a_hit_only_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && out_hit_next) |-> (action_reg == ACT_LOOKUP))
        else $error("hit reported for a non-lookup request");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the commit step");

    a_hits_drop_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (hit_cnt_next < hit_cnt_reg)) |-> (action_reg == ACT_CLEAR))
        else $error("hit total decreased without a clear");
`endif

endmodule

[dv/tb.sv]
// Testbench for the fully associative LRU cache: stream driver, checker and predictor.
`timescale 1ns / 1ps

module tb
    import falc_pkg::*;
();

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 10;
    localparam int RANDOM_REQS = 800;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 2 * ENTRIES + 8;
    localparam int POOL_SIZE   = 12;

    typedef struct {
        action_t            act;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  fill;
    } cache_req_t;

    typedef struct {
        logic               hit;
        logic [DATA_W-1:0]  read_block;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
    } cache_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = ACT_LOOKUP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;

    // Predicted cache contents
    logic               line_valid [ENTRIES];
    logic [TAG_W-1:0]   line_tag   [ENTRIES];
    logic [DATA_W-1:0]  line_data  [ENTRIES];
    logic [STAMP_W-1:0] line_stamp [ENTRIES];
    logic [STAMP_W-1:0] stamp_now;
    logic [CNT_W-1:0]   hit_sum;
    logic [CNT_W-1:0]   miss_sum;

    cache_req_t req_queue[$];
    cache_rsp_t rsp_queue[$];

    int  req_count;
    int  req_taken_count = 0;
    int  cycle_count = 0;
    int  error_count = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  calm_left = 0;
    int  lookup_count = 0;
    int  lookup_hits = 0;
    int  evict_count = 0;
    int  flush_count = 0;
    int  clear_count = 0;
    int  result_count = 0;
    logic req_taken = 1'b0;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    fully_assoc_lru_data_cache_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Idle length: mostly short, a few long, with calm stretches of none
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (roll < 2) begin
            calm_left = $urandom_range(30, 80);
            return 0;
        end
        if (roll < 45)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one request to the predicted cache and build its result
    task automatic predict_access(input cache_req_t req, output cache_rsp_t rsp);
        logic [TAG_W-1:0] tag;
        int victim;
        rsp = '{hit: 1'b0, read_block: '0, hit_total: '0, miss_total: '0};
        tag = req.addr[OFFSET_W +: TAG_W];
        victim = -1;
        case (req.act)
            ACT_LOOKUP:
            begin
                lookup_count++;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (rsp.hit == 1'b0 && line_valid[i] && line_tag[i] == tag)
                    begin
                        rsp.hit = 1'b1;
                        rsp.read_block = line_data[i];
                        line_stamp[i] = stamp_now;
                        stamp_now = stamp_now + 1'b1;
                    end
                end
                if (rsp.hit)
                begin
                    lookup_hits++;
                    if (hit_sum != '1)
                        hit_sum = hit_sum + 1'b1;
                end
                else if (miss_sum != '1)
                    miss_sum = miss_sum + 1'b1;
            end
            ACT_INSERT:
            begin
                // Lowest free entry first, else oldest stamp, lowest index on a tie
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!line_valid[i])
                        victim = i;
                if (victim < 0)
                begin
                    evict_count++;
                    victim = 0;
                    for (int i = 1; i < ENTRIES; i++)
                        if (line_stamp[i] < line_stamp[victim])
                            victim = i;
                end
                line_valid[victim] = 1'b1;
                line_tag[victim]   = tag;
                line_data[victim]  = req.fill;
                line_stamp[victim] = stamp_now;
                stamp_now = stamp_now + 1'b1;
            end
            ACT_INVALIDATE:
            begin
                flush_count++;
                for (int i = 0; i < ENTRIES; i++)
                    line_valid[i] = 1'b0;
            end
            default:
            begin
                clear_count++;
                hit_sum  = '0;
                miss_sum = '0;
            end
        endcase
        rsp.hit_total  = hit_sum;
        rsp.miss_total = miss_sum;
    endtask

    task automatic add_req(input action_t act, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] fill);
        req_queue.push_back('{act: act, addr: addr, fill: fill});
    endtask

    // Pick a lookup or insert address, mostly from a small reused set
    function automatic logic [ADDR_W-1:0] pick_addr();
        int slot;
        if ($urandom_range(0, 99) < 15)
            return ADDR_W'($urandom);
        slot = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 99) < 3)
            addr_pool[slot] = ADDR_W'($urandom);
        // Vary the ignored offset bits on reuse
        return addr_pool[slot] ^ ADDR_W'($urandom_range(0, BLOCK_BYTES - 1));
    endfunction

    // Drive requests at the falling edge
    always @(negedge clk)
    begin : request_drive
        cache_req_t nxt;
        if (rst_n && (!s_tvalid || req_taken))
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap--;
            end
            else if (req_queue.size() > 0)
            begin
                nxt = req_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.act;
                s_tdata  <= {nxt.fill, nxt.addr};
                send_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
    begin : result_stall
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                m_tready <= 1'b0;
                recv_stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    // Predict on every request transfer
    always @(posedge clk)
    begin : request_accept
        cache_req_t req;
        cache_rsp_t rsp;
        req_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            req.act  = action_t'(s_tuser);
            req.addr = s_tdata[15:0];
            req.fill = s_tdata[47:16];
            predict_access(req, rsp);
            rsp_queue.push_back(rsp);
            req_taken_count++;
        end
    end

    // Compare every result transfer against the oldest prediction
    always @(posedge clk)
    begin : result_check
        cache_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rsp_queue.size() == 0)
                report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            else
            begin
                want = rsp_queue.pop_front();
                result_count++;
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", 32'(m_tuser[0]), 32'(want.hit));
                if (m_tdata[31:0] !== want.read_block)
                    report_mismatch("read_block", m_tdata[31:0], want.read_block);
                if (m_tdata[63:32] !== want.hit_total)
                    report_mismatch("hit_total", m_tdata[63:32], want.hit_total);
                if (m_tdata[95:64] !== want.miss_total)
                    report_mismatch("miss_total", m_tdata[95:64], want.miss_total);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[%0t] timeout with %0d results outstanding", $realtime,
                     rsp_queue.size());
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int roll;
        for (int i = 0; i < ENTRIES; i++)
        begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_data[i]  = '0;
            line_stamp[i] = '0;
        end
        stamp_now = '0;
        hit_sum   = '0;
        miss_sum  = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = ADDR_W'($urandom);

        // Directed: empty miss, extremes, fill, LRU eviction, duplicates, clear, flush
        add_req(ACT_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
        add_req(ACT_INSERT, 16'h0000, 32'h0000_0000);
        add_req(ACT_LOOKUP, 16'h0003, 32'h0);
        add_req(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        add_req(ACT_LOOKUP, 16'hFFFC, 32'h0);
        for (int i = 1; i <= ENTRIES - 2; i++)
            add_req(ACT_INSERT, ADDR_W'(i * 16'h1234), ~(i * 32'h0101_0101));
        add_req(ACT_LOOKUP, 16'h0001, 32'h0);
        add_req(ACT_INSERT, 16'h4444, 32'h5555_AAAA);
        add_req(ACT_LOOKUP, 16'hFFFF, 32'h0);
        add_req(ACT_INSERT, 16'h4446, 32'hAAAA_5555);
        add_req(ACT_LOOKUP, 16'h4445, 32'h0);
        add_req(ACT_CLEAR, 16'h0000, 32'h0);
        add_req(ACT_LOOKUP, 16'h0002, 32'h0);
        add_req(ACT_INVALIDATE, 16'hFFFF, 32'hFFFF_FFFF);
        add_req(ACT_LOOKUP, 16'h0000, 32'h0);
        add_req(ACT_INSERT, 16'h0000, 32'hA5A5_A5A5);
        add_req(ACT_LOOKUP, 16'h0000, 32'h0);

        // Random: lookups and inserts over a reused address set, rare flush and clear
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 52)
                add_req(ACT_LOOKUP, pick_addr(), $urandom);
            else if (roll < 92)
                add_req(ACT_INSERT, pick_addr(), $urandom);
            else if (roll < 96)
                add_req(ACT_INVALIDATE, ADDR_W'($urandom), $urandom);
            else
                add_req(ACT_CLEAR, ADDR_W'($urandom), $urandom);
        end
        req_count = req_queue.size();

        // Hold reset, then release at a falling edge
        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (req_taken_count == req_count);
        wait (rsp_queue.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d requests: %0d lookups (%0d hits), %0d LRU evictions",
                 req_taken_count, lookup_count, lookup_hits, evict_count);
        $display("with %0d flushes and %0d counter clears; %0d results checked, %0d errors",
                 flush_count, clear_count, result_count, error_count);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
